FILE: src/obc_pkg.sv
package obc_pkg;

  localparam int CoordW       = 32;
  localparam int AngleW       = 16;
  localparam int SizeW        = 24;
  localparam int LenW         = SizeW + 1;
  localparam int TrigW        = 16;
  localparam int CordicW      = 33;
  localparam int CORDIC_STEPS = 16;
  localparam int AtanEntries  = 24;
  localparam int QueueDepth   = 2;
  localparam int QPtrW        = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW        = $clog2(QueueDepth + 1);

  localparam logic signed [CordicW-1:0] GainInv   = CordicW'(652032874);
  localparam logic signed [CordicW-1:0] TrigMax   = CordicW'(32767);
  localparam logic signed [CordicW-1:0] TrigRound = CordicW'(16384);
  localparam int TrigShift = 15;

  typedef enum logic [1:0] {
    CORNER_MM = 2'd0,
    CORNER_PM = 2'd1,
    CORNER_PP = 2'd2,
    CORNER_MP = 2'd3
  } corner_e;

  typedef struct packed {
    logic signed [CoordW-1:0] centre_x;
    logic signed [CoordW-1:0] centre_y;
    logic signed [AngleW-1:0] heading;
    logic [SizeW-1:0]         box_width;
    logic [SizeW-1:0]         box_depth;
    logic [SizeW-1:0]         margin;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               corner_index;
    logic signed [CoordW-1:0] corner_x;
    logic signed [CoordW-1:0] corner_y;
    logic                     last;
  } out_item_t;

  // One rectangle after the trig stage, waiting for the corner sequencer.
  typedef struct packed {
    logic signed [CoordW-1:0] centre_x;
    logic signed [CoordW-1:0] centre_y;
    logic [LenW-1:0]          s_len;
    logic [LenW-1:0]          t_len;
    logic signed [TrigW-1:0]  cos_v;
    logic signed [TrigW-1:0]  sin_v;
  } job_t;

  // Arctangent of 2^-i, with 2^31 standing for pi.
  function automatic logic signed [CordicW-1:0] atan_unit(input int unsigned i);
    logic signed [CordicW-1:0] v;
    unique case (i)
      0:       v = CordicW'(536870912);
      1:       v = CordicW'(316933406);
      2:       v = CordicW'(167458907);
      3:       v = CordicW'(85004756);
      4:       v = CordicW'(42667331);
      5:       v = CordicW'(21354465);
      6:       v = CordicW'(10679838);
      7:       v = CordicW'(5340245);
      8:       v = CordicW'(2670163);
      9:       v = CordicW'(1335087);
      10:      v = CordicW'(667544);
      11:      v = CordicW'(333772);
      12:      v = CordicW'(166886);
      13:      v = CordicW'(83443);
      14:      v = CordicW'(41722);
      15:      v = CordicW'(20861);
      16:      v = CordicW'(10430);
      17:      v = CordicW'(5215);
      18:      v = CordicW'(2608);
      19:      v = CordicW'(1304);
      20:      v = CordicW'(652);
      21:      v = CordicW'(326);
      22:      v = CordicW'(163);
      23:      v = CordicW'(81);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/oriented_box_corners.sv
// Oriented box corners.
// Input channel: in_valid_i / in_stall_o with one rectangle per beat in
// in_item_i (centre, heading, width, depth, margin). Output channel:
// out_valid_o / out_stall_i with one corner per beat in out_item_o, four
// beats per rectangle in the order (-,-), (+,-), (+,+), (-,+), the fourth
// one flagged by last.
// The corner sequencer emits one corner per cycle while the receiver does
// not stall, and takes the next rectangle from the queue with the last
// corner of the one before. The sine/cosine pipeline in front takes a
// rectangle every cycle unless it holds for a full queue, and feeds a
// two-entry queue. From input beat to the first corner, a rectangle passes
// the fold register that takes the beat, one register per rotation step,
// trig rounding, the queue, then product, offset and output registers; the
// other three corners follow one after another.
// Reset empties the pipeline, the queue and the output register; no
// configuration is needed. When the receiver stalls, the output beat holds,
// the queue fills, and in_stall_o rises once the queue is full and the
// trig pipeline has a finished rectangle it cannot hand on.
module oriented_box_corners (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  obc_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output obc_pkg::out_item_t out_item_o
);
  import obc_pkg::*;

  logic q_full, q_push, q_pop, q_valid;
  job_t q_in, q_head;

  obc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .job_o      (q_in)
  );

  obc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  obc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .job_i       (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: src/obc_front.sv
module obc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  obc_pkg::in_item_t in_item_i,
  input  logic             q_full_i,
  output logic             push_o,
  output obc_pkg::job_t    job_o
);
  import obc_pkg::*;

  typedef struct packed {
    logic signed [CordicW-1:0] x;
    logic signed [CordicW-1:0] y;
    logic signed [CordicW-1:0] z;
    logic                      flip;
    logic signed [CoordW-1:0]  centre_x;
    logic signed [CoordW-1:0]  centre_y;
    logic [LenW-1:0]           s_len;
    logic [LenW-1:0]           t_len;
  } cordic_t;

  logic                adv;
  logic [CORDIC_STEPS:0] vld_q;
  cordic_t             st_q [CORDIC_STEPS+1];
  cordic_t             st_d [CORDIC_STEPS+1];
  logic                job_vld_q;
  job_t                job_q, job_d;

  // The whole pipeline moves as one; it only holds when the last stage cannot
  // hand its beat to the queue.
  assign adv        = !job_vld_q || !q_full_i;
  assign in_stall_o = !adv;
  assign push_o     = job_vld_q && !q_full_i;
  assign job_o      = job_q;

  always_comb begin
    logic signed [AngleW:0]    h_ext;
    logic signed [AngleW:0]    h_fold;
    logic                      flip;
    logic signed [CordicW-1:0] xs;
    logic signed [CordicW-1:0] ys;
    logic signed [CordicW-1:0] ang;
    h_ext = {in_item_i.heading[AngleW-1], in_item_i.heading};
    flip  = 1'b0;
    // Fold the heading into the half circle around zero; the turn by pi
    // is undone by negating both trig values at the end.
    if (h_ext > 17'sd16384) begin
      h_fold = h_ext - 17'sd32768;
      flip   = 1'b1;
    end else if (h_ext < -17'sd16384) begin
      h_fold = h_ext + 17'sd32768;
      flip   = 1'b1;
    end else begin
      h_fold = h_ext;
    end
    st_d[0].x        = GainInv;
    st_d[0].y        = '0;
    st_d[0].z        = $signed({h_fold, 16'h0000});
    st_d[0].flip     = flip;
    st_d[0].centre_x = in_item_i.centre_x;
    st_d[0].centre_y = in_item_i.centre_y;
    st_d[0].s_len    = {1'b0, in_item_i.box_width} + {1'b0, in_item_i.margin};
    st_d[0].t_len    = {1'b0, in_item_i.box_depth} + {1'b0, in_item_i.margin};

    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs  = st_q[i].x >>> i;
      ys  = st_q[i].y >>> i;
      ang = atan_unit(i);
      st_d[i+1] = st_q[i];
      // Steps past the end of the arctangent table leave the vector as it is.
      if (i < AtanEntries) begin
        if (!st_q[i].z[CordicW-1]) begin
          st_d[i+1].x = st_q[i].x - ys;
          st_d[i+1].y = st_q[i].y + xs;
          st_d[i+1].z = st_q[i].z - ang;
        end else begin
          st_d[i+1].x = st_q[i].x + ys;
          st_d[i+1].y = st_q[i].y - xs;
          st_d[i+1].z = st_q[i].z + ang;
        end
      end
    end
  end

  always_comb begin
    logic signed [CordicW-1:0] xf;
    logic signed [CordicW-1:0] yf;
    logic signed [CordicW-1:0] xr;
    logic signed [CordicW-1:0] yr;
    xf = st_q[CORDIC_STEPS].flip ? -st_q[CORDIC_STEPS].x : st_q[CORDIC_STEPS].x;
    yf = st_q[CORDIC_STEPS].flip ? -st_q[CORDIC_STEPS].y : st_q[CORDIC_STEPS].y;
    xr = (xf + TrigRound) >>> TrigShift;
    yr = (yf + TrigRound) >>> TrigShift;
    if (xr > TrigMax) xr = TrigMax;
    if (xr < -TrigMax) xr = -TrigMax;
    if (yr > TrigMax) yr = TrigMax;
    if (yr < -TrigMax) yr = -TrigMax;
    job_d.centre_x = st_q[CORDIC_STEPS].centre_x;
    job_d.centre_y = st_q[CORDIC_STEPS].centre_y;
    job_d.s_len    = st_q[CORDIC_STEPS].s_len;
    job_d.t_len    = st_q[CORDIC_STEPS].t_len;
    job_d.cos_v    = xr[TrigW-1:0];
    job_d.sin_v    = yr[TrigW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      job_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[CORDIC_STEPS-1:0], in_valid_i};
      job_vld_q <= vld_q[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i <= CORDIC_STEPS; i++) begin
        st_q[i] <= st_d[i];
      end
      job_q <= job_d;
    end
  end

endmodule

FILE: src/obc_queue.sv
module obc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  obc_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output obc_pkg::job_t head_o
);
  import obc_pkg::*;

  job_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;

  assign full_o  = (count_q == QCntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  function automatic logic [QPtrW-1:0] ptr_next(input logic [QPtrW-1:0] p);
    return (p == QPtrW'(QueueDepth - 1)) ? '0 : p + QPtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_next(rd_ptr_q);
      if (push_i && !pop_i) begin
        count_q <= count_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

FILE: src/obc_back.sv
module obc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  obc_pkg::job_t     job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output obc_pkg::out_item_t out_item_o
);
  import obc_pkg::*;

  localparam int ProdW     = TrigW + LenW + 1;
  localparam int SumW      = ProdW + 1;
  localparam int HalfShift = 16;
  localparam int OffW      = SumW - HalfShift;
  localparam logic signed [SumW-1:0] HalfLsb = SumW'(32768);

  logic    adv, issue, sx, sy;
  corner_e k_q;
  logic    v1_q, v2_q, ov_q;

  logic signed [LenW:0]    s_ext, t_ext, lx, ly;
  logic signed [ProdW-1:0] p_cx_q, p_sy_q, p_sx_q, p_cy_q;
  logic signed [CoordW-1:0] cx1_q, cy1_q, cx2_q, cy2_q;
  corner_e                 idx1_q, idx2_q;
  logic signed [SumW-1:0]  sum_x, sum_y;
  logic signed [OffW-1:0]  off_x_q, off_y_q;
  out_item_t               out_q;

  // Each queued rectangle is issued four times, one corner a beat, and
  // leaves the queue with its last corner.
  assign adv         = !ov_q || !out_stall_i;
  assign issue       = adv && q_valid_i;
  assign pop_o       = issue && (k_q == CORNER_MP);
  assign out_valid_o = ov_q;
  assign out_item_o  = out_q;

  always_comb begin
    sx    = (k_q == CORNER_PM) || (k_q == CORNER_PP);
    sy    = (k_q == CORNER_PP) || (k_q == CORNER_MP);
    s_ext = $signed({1'b0, job_i.s_len});
    t_ext = $signed({1'b0, job_i.t_len});
    lx    = sx ? s_ext : -s_ext;
    ly    = sy ? t_ext : -t_ext;
    sum_x = SumW'(p_cx_q) - SumW'(p_sy_q) + HalfLsb;
    sum_y = SumW'(p_sx_q) + SumW'(p_cy_q) + HalfLsb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q  <= CORNER_MM;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv) begin
      v1_q <= q_valid_i;
      v2_q <= v1_q;
      ov_q <= v2_q;
      if (issue) k_q <= corner_e'(k_q + 2'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_cx_q <= ProdW'(job_i.cos_v) * ProdW'(lx);
      p_sy_q <= ProdW'(job_i.sin_v) * ProdW'(ly);
      p_sx_q <= ProdW'(job_i.sin_v) * ProdW'(lx);
      p_cy_q <= ProdW'(job_i.cos_v) * ProdW'(ly);
      cx1_q  <= job_i.centre_x;
      cy1_q  <= job_i.centre_y;
      idx1_q <= k_q;

      // Dropping sixteen bits halves the size and removes the trig fraction.
      off_x_q <= sum_x[SumW-1:HalfShift];
      off_y_q <= sum_y[SumW-1:HalfShift];
      cx2_q   <= cx1_q;
      cy2_q   <= cy1_q;
      idx2_q  <= idx1_q;

      out_q.corner_index <= idx2_q;
      out_q.corner_x     <= cx2_q + CoordW'(off_x_q);
      out_q.corner_y     <= cy2_q + CoordW'(off_y_q);
      out_q.last         <= (idx2_q == CORNER_MP);
    end
  end

endmodule
